>>> src/psrl_pkg.sv
// Package for the per-source rate limiter: widths, reset values, codes and
// the structs passed between the top level and the source table.
// No dependencies.
package psrl_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned IpW             = 32;
  localparam int unsigned CountW          = 17;
  localparam int unsigned CfgW            = 16;
  localparam int unsigned TimeW           = 32;
  localparam int unsigned CfgIdxW         = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgW-1:0] RateLimitRst     = 16'd100;
  localparam logic [CfgW-1:0] WindowSecondsRst = 16'd60;
  localparam logic [CfgW-1:0] BlockSecondsRst  = 16'd300;

  typedef enum logic {
    CmdRequest = 1'b0,
    CmdTick    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    VerdictAccept  = 2'd0,
    VerdictDropped = 2'd1,
    VerdictBlocked = 2'd2,
    VerdictFull    = 2'd3
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRateLimit     = 2'd0,
    CfgWindowSeconds = 2'd1,
    CfgBlockSeconds  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] rate_limit;
    logic [CfgW-1:0] window_seconds;
    logic [CfgW-1:0] block_seconds;
  } cfg_t;

  typedef struct packed {
    logic           req;
    logic           tick;
    logic           clear_counts;
    logic [IpW-1:0] ip;
  } tbl_op_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [CountW-1:0] hit_count;
  } tbl_res_t;

endpackage

>>> src/psrl_if.sv
// Valid/ready channel interfaces for the rate limiter's input and result items.
// Depends on psrl_pkg.
interface psrl_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [psrl_pkg::IpW-1:0]  src_ip;

  modport source (output valid, output cmd, output src_ip, input ready);
  modport sink   (input valid, input cmd, input src_ip, output ready);
endinterface

interface psrl_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   verdict;
  logic [psrl_pkg::CountW-1:0]  hit_count;

  modport source (output valid, output verdict, output hit_count, input ready);
  modport sink   (input valid, input verdict, input hit_count, output ready);
endinterface

>>> src/psrl_table.sv
// Fully associative source table: address match, free slot pick, verdict and
// per-entry update for requests and ticks. Depends on psrl_pkg.
module psrl_table #(
  parameter int unsigned TableEntries = psrl_pkg::TableEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psrl_pkg::cfg_t               cfg_i,
  input  logic [psrl_pkg::TimeW-1:0]   now_i,
  input  logic [psrl_pkg::TimeW-1:0]   now_next_i,
  input  psrl_pkg::tbl_op_t            op_i,
  output psrl_pkg::tbl_res_t           res_o
);
  import psrl_pkg::*;

  logic [TableEntries-1:0] valid_q;
  logic [TableEntries-1:0] blocked_q;
  logic [CountW-1:0]       count_q [TableEntries];
  logic [IpW-1:0]          addr_q  [TableEntries];
  logic [TimeW-1:0]        start_q [TableEntries];

  logic [TableEntries-1:0] match;
  logic [TableEntries-1:0] free_oh;
  logic [TableEntries-1:0] wr_oh;
  logic [TableEntries-1:0] tick_free;
  logic [CountW-1:0]       tick_count [TableEntries];
  logic                    hit_any;
  logic                    free_any;
  logic [CountW-1:0]       sel_count;
  logic                    sel_blocked;
  logic [TimeW-1:0]        sel_start;
  logic [TimeW-1:0]        block_len;
  logic                    running;
  logic [CountW-1:0]       base_count;
  logic [CountW-1:0]       inc_count;
  logic                    over;

  assign block_len = {{(TimeW-CfgW){1'b0}}, cfg_i.block_seconds};

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      match[i] = valid_q[i] && (addr_q[i] == op_i.ip);
    end
  end

  // Lowest clear bit of the valid vector, as a one-hot word.
  assign free_oh  = ~valid_q & (valid_q + {{(TableEntries-1){1'b0}}, 1'b1});
  assign hit_any  = |match;
  assign free_any = |free_oh;

  // A source is stored at most once, so the match vector is one-hot or zero.
  always_comb begin
    sel_count   = '0;
    sel_blocked = 1'b0;
    sel_start   = '0;
    for (int i = 0; i < TableEntries; i++) begin
      sel_count   = sel_count   | (count_q[i] & {CountW{match[i]}});
      sel_blocked = sel_blocked | (blocked_q[i] & match[i]);
      sel_start   = sel_start   | (start_q[i] & {TimeW{match[i]}});
    end
  end

  assign running    = sel_blocked && ((now_i - sel_start) < block_len);
  assign base_count = hit_any ? sel_count : '0;
  assign inc_count  = (base_count == CountMax) ? base_count : base_count + 1'b1;
  assign over       = inc_count > {1'b0, cfg_i.rate_limit};

  always_comb begin
    wr_oh         = '0;
    res_o.verdict   = VerdictAccept;
    res_o.hit_count = inc_count;
    if (!hit_any && !free_any) begin
      res_o.verdict   = VerdictFull;
      res_o.hit_count = '0;
    end else if (hit_any && running) begin
      res_o.verdict   = VerdictDropped;
      res_o.hit_count = sel_count;
    end else begin
      wr_oh         = hit_any ? match : free_oh;
      res_o.verdict = over ? VerdictBlocked : VerdictAccept;
    end
  end

  // On a tick each entry drops its count at a window end and is freed once
  // its count is zero and its block has run out at the new time.
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      tick_count[i] = op_i.clear_counts ? '0 : count_q[i];
      tick_free[i]  = valid_q[i] && (tick_count[i] == '0) &&
                      !(blocked_q[i] && ((now_next_i - start_q[i]) < block_len));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      blocked_q <= '0;
      for (int i = 0; i < TableEntries; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TableEntries; i++) begin
        if (op_i.tick) begin
          count_q[i] <= tick_count[i];
          if (tick_free[i]) begin
            valid_q[i]   <= 1'b0;
            blocked_q[i] <= 1'b0;
          end
        end else if (op_i.req && wr_oh[i]) begin
          valid_q[i]   <= 1'b1;
          blocked_q[i] <= over;
          count_q[i]   <= inc_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TableEntries; i++) begin
      if (op_i.req && wr_oh[i]) begin
        addr_q[i] <= op_i.ip;
        if (over) begin
          start_q[i] <= now_i;
        end
      end
    end
  end

endmodule

>>> src/per_source_rate_limiter.sv
// Per-source request rate limiter with a blocklist: top level with the
// channel registers, seconds clock and configuration registers.
// Depends on psrl_pkg, psrl_if and psrl_table.
//
// Usage: items enter on in_i; cmd 0 is a request carrying src_ip, cmd 1 is a
// one-second tick. Each request gives exactly one result item on out_o with a
// verdict and the source's request count; a tick gives none. Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i while the block is idle;
// the user must keep to that, as the block itself does not enforce it. An
// accepted request passes from the input register through the table into the
// result register. Throughput: one item per cycle while out_o takes results;
// the lookup, verdict and entry update of one item are a single pass between
// the two registers, so the next item sees the updated table the next cycle.
// Reset clears the table's valid and blocked marks and counts, the seconds
// clock and window counter, and loads the default configuration. No clearing
// pass is needed; the first item can be accepted right after reset.
// When out_o stalls, the result stays in the output register, the next item
// waits in the input register, and in_i.ready drops; ticks still pass.
module per_source_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = psrl_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psrl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psrl_pkg::CfgW-1:0]      cfg_wdata_i,
  psrl_in_if.sink                        in_i,
  psrl_out_if.source                     out_o
);
  import psrl_pkg::*;

  cfg_t              cfg_q;
  logic              in_valid_q;
  cmd_e              cmd_q;
  logic [IpW-1:0]    ip_q;
  logic              out_valid_q;
  verdict_e          verdict_q;
  logic [CountW-1:0] count_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  now_d;
  logic [CfgW-1:0]   win_q;
  logic [CfgW-1:0]   win_inc;
  logic              win_end;
  logic              proc;
  tbl_op_t           op;
  tbl_res_t          res;

  assign proc = in_valid_q && ((cmd_q == CmdTick) || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || proc;

  assign now_d   = now_q + 1'b1;
  assign win_inc = win_q + 1'b1;
  assign win_end = win_inc >= cfg_q.window_seconds;

  assign op.req          = proc && (cmd_q == CmdRequest);
  assign op.tick         = proc && (cmd_q == CmdTick);
  assign op.clear_counts = win_end;
  assign op.ip           = ip_q;

  psrl_table #(
    .TableEntries(TABLE_ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .now_i      (now_q),
    .now_next_i (now_d),
    .op_i       (op),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_limit     <= RateLimitRst;
      cfg_q.window_seconds <= WindowSecondsRst;
      cfg_q.block_seconds  <= BlockSecondsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRateLimit:     cfg_q.rate_limit     <= cfg_wdata_i;
        CfgWindowSeconds: cfg_q.window_seconds <= cfg_wdata_i;
        CfgBlockSeconds:  cfg_q.block_seconds  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      now_q       <= '0;
      win_q       <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (op.req) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (op.tick) begin
        now_q <= now_d;
        win_q <= win_end ? '0 : win_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= cmd_e'(in_i.cmd);
      ip_q  <= in_i.src_ip;
    end
    if (op.req) begin
      verdict_q <= res.verdict;
      count_q   <= res.hit_count;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.verdict   = verdict_q;
  assign out_o.hit_count = count_q;

  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc && (cmd_q == CmdRequest)))
    else $error("Result appeared without a processed request.");

  a_tick_advances_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (cmd_q == CmdTick)) |=> (now_q == $past(now_q) + 1'b1))
    else $error("Seconds clock did not advance on a tick.");

  a_full_has_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (verdict_q == VerdictFull)) |-> (count_q == '0))
    else $error("Table full verdict carries a nonzero count.");

  a_waiting_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc) |=> (in_valid_q && $stable(ip_q) && $stable(cmd_q)))
    else $error("Waiting input item was lost or changed.");

endmodule
